[design/kplc_pkg.sv]
// shared types, constants and defaults of the keypad password lock controller
`timescale 1ns / 1ps

package kplc_pkg;

   localparam int PASS_LEN_DEFAULT       = 5;
   localparam int MISMATCH_TRIES_DEFAULT = 5;

   localparam int KEY_W  = 8;
   localparam int CMD_W  = 5;
   localparam int MOT_W  = 2;
   localparam int TL_W   = 3;
   localparam int CSR_AW = 3;
   localparam int LIM_W  = 4;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_BACKSPACE_KEY = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_CLEAR_KEY     = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_ENTER_KEY     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_DIGIT_LOW     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_DIGIT_HIGH    = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_OPEN_KEY      = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_CHANGE_KEY    = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_WRONG_LIMIT   = 3'd7;

   localparam logic [KEY_W-1:0] BACKSPACE_KEY_RST = 8'd45;
   localparam logic [KEY_W-1:0] CLEAR_KEY_RST     = 8'd99;
   localparam logic [KEY_W-1:0] ENTER_KEY_RST     = 8'd61;
   localparam logic [KEY_W-1:0] DIGIT_LOW_RST     = 8'd48;
   localparam logic [KEY_W-1:0] DIGIT_HIGH_RST    = 8'd57;
   localparam logic [KEY_W-1:0] OPEN_KEY_RST      = 8'd43;
   localparam logic [KEY_W-1:0] CHANGE_KEY_RST    = 8'd45;
   localparam logic [LIM_W-1:0] WRONG_LIMIT_RST   = 4'd3;

   // display commands
   localparam logic [CMD_W-1:0] CMD_NONE         = 5'd0;
   localparam logic [CMD_W-1:0] CMD_SHOW_MENU    = 5'd1;
   localparam logic [CMD_W-1:0] CMD_MENU_REJECT  = 5'd2;
   localparam logic [CMD_W-1:0] CMD_NEW_PASS     = 5'd3;
   localparam logic [CMD_W-1:0] CMD_CONFIRM_PASS = 5'd4;
   localparam logic [CMD_W-1:0] CMD_PASS_CHANGED = 5'd5;
   localparam logic [CMD_W-1:0] CMD_MISMATCH     = 5'd6;
   localparam logic [CMD_W-1:0] CMD_UNLOCKING    = 5'd7;
   localparam logic [CMD_W-1:0] CMD_UNLOCKED     = 5'd8;
   localparam logic [CMD_W-1:0] CMD_LOCKING      = 5'd9;
   localparam logic [CMD_W-1:0] CMD_ENTER_PASS   = 5'd10;
   localparam logic [CMD_W-1:0] CMD_WRONG_PASS   = 5'd11;
   localparam logic [CMD_W-1:0] CMD_DENIED       = 5'd12;
   localparam logic [CMD_W-1:0] CMD_ERASE_LAST   = 5'd13;
   localparam logic [CMD_W-1:0] CMD_ERASE_ALL    = 5'd14;
   localparam logic [CMD_W-1:0] CMD_DIGIT_OK     = 5'd15;
   localparam logic [CMD_W-1:0] CMD_KEY_SKIPPED  = 5'd17;

   // motor drive levels
   localparam logic [MOT_W-1:0] MOTOR_STOP    = 2'd0;
   localparam logic [MOT_W-1:0] MOTOR_FORWARD = 2'd1;
   localparam logic [MOT_W-1:0] MOTOR_REVERSE = 2'd2;

   // timer loads
   localparam logic [TL_W-1:0] TL_NONE    = 3'd0;
   localparam logic [TL_W-1:0] TL_MESSAGE = 3'd1;
   localparam logic [TL_W-1:0] TL_UNLOCK  = 3'd2;
   localparam logic [TL_W-1:0] TL_HOLD    = 3'd3;
   localparam logic [TL_W-1:0] TL_LOCK    = 3'd4;
   localparam logic [TL_W-1:0] TL_WARNING = 3'd5;

   typedef struct packed {
      logic             mode;
      logic [KEY_W-1:0] key;
   } kplc_req_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [MOT_W-1:0] motor_drive;
      logic             buzzer;
      logic [TL_W-1:0]  timer_load;
   } kplc_rsp_type;

   // requests from the sequencer to the password store
   typedef struct packed {
      logic             wr_en;
      logic [KEY_W-1:0] wr_data;
      logic             copy_new;
      logic             commit;
      logic             cmp_start;
      logic             cmp_stored;
   } kplc_store_op_type;

   typedef struct packed {
      logic cmp_done;
      logic cmp_equal;
   } kplc_store_stat_type;

endpackage

[design/kplc_store.sv]
// password registers with a byte-serial comparator
`timescale 1ns / 1ps

module kplc_store #(
   parameter int PASS_LEN = kplc_pkg::PASS_LEN_DEFAULT,
   parameter int IDX_W    = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  kplc_pkg::kplc_store_op_type  op,
   input  logic [IDX_W-1:0]             wr_idx,
   output kplc_pkg::kplc_store_stat_type stat
);
   import kplc_pkg::*;

   logic [KEY_W-1:0] entry_mem  [PASS_LEN];
   logic [KEY_W-1:0] new_mem    [PASS_LEN];
   logic [KEY_W-1:0] stored_mem [PASS_LEN];

   logic             busy_ff;
   logic             done_ff;
   logic             eq_ff;
   logic             sel_stored_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [KEY_W-1:0] lhs;
   logic [KEY_W-1:0] rhs;

   always_ff @(posedge clock) begin
      if (op.wr_en) begin
         entry_mem[wr_idx] <= op.wr_data;
      end
      if (op.copy_new) begin
         new_mem <= entry_mem;
      end
      if (op.commit) begin
         stored_mem <= entry_mem;
      end
   end

   assign lhs = sel_stored_ff ? stored_mem[idx_ff] : new_mem[idx_ff];
   assign rhs = entry_mem[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (op.cmp_start) begin
            busy_ff       <= 1'b1;
            idx_ff        <= '0;
            eq_ff         <= 1'b1;
            sel_stored_ff <= op.cmp_stored;
         end else if (busy_ff) begin
            eq_ff <= eq_ff & (lhs == rhs);
            if (idx_ff == IDX_W'(PASS_LEN - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   assign stat.cmp_done  = done_ff;
   assign stat.cmp_equal = eq_ff;

endmodule

[design/keypad_password_lock_controller.sv]
// top level of the keypad password lock controller
`timescale 1ns / 1ps

// One keypad byte or timer event goes in, one result (display command, motor drive, buzzer,
// timer load) comes out. The block takes one item at a time, through the decode and post
// states; an entry that an enter key submits for a check also passes the compare state, where
// the password store compares one byte per cycle in its shared comparator. A result waits in
// an output register until it is taken; the next item is taken once the result register is
// loaded. The password registers hold no defined value until first written.

module keypad_password_lock_controller #(
   parameter int PASS_LEN       = kplc_pkg::PASS_LEN_DEFAULT,
   parameter int MISMATCH_TRIES = kplc_pkg::MISMATCH_TRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  kplc_pkg::kplc_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output kplc_pkg::kplc_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [kplc_pkg::CSR_AW-1:0]        csr_addr,
   input  logic [kplc_pkg::KEY_W-1:0]         csr_wdata
);
   import kplc_pkg::*;

   localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
   localparam int CNT_W = $clog2(PASS_LEN + 1);

   typedef enum logic [1:0] {S_IDLE, S_DECODE, S_CMP, S_POST} seq_type;
   typedef enum logic [1:0] {ST_MENU, ST_CHANGE, ST_OPEN, ST_AUTH} top_type;
   typedef enum logic [2:0] {EK_BACK, EK_CLEAR, EK_DIGIT, EK_SUBMIT, EK_SKIP} ek_type;

   logic [KEY_W-1:0] backspace_key_ff, clear_key_ff, enter_key_ff;
   logic [KEY_W-1:0] digit_low_ff, digit_high_ff, open_key_ff, change_key_ff;
   logic [LIM_W-1:0] wrong_limit_ff;

   seq_type          seq_ff, seq_in;
   top_type          top_ff, top_in;
   top_type          prior_ff, prior_in;
   logic [1:0]       step_ff, step_in;
   logic             first_ff, first_in;
   logic [LIM_W-1:0] trial_ff, trial_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [TL_W-1:0]  tload_ff, tload_in;
   kplc_req_type     item_ff;
   logic             rsp_valid_ff;
   kplc_rsp_type     rsp_data_ff;

   kplc_store_op_type   op;
   kplc_store_stat_type stat;
   ek_type              ek;
   logic                timer;
   logic                entry_active;
   logic [LIM_W-1:0]    trial_bump;
   logic [MOT_W-1:0]    motor;
   logic                buzz;
   logic                slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         backspace_key_ff <= BACKSPACE_KEY_RST;
         clear_key_ff     <= CLEAR_KEY_RST;
         enter_key_ff     <= ENTER_KEY_RST;
         digit_low_ff     <= DIGIT_LOW_RST;
         digit_high_ff    <= DIGIT_HIGH_RST;
         open_key_ff      <= OPEN_KEY_RST;
         change_key_ff    <= CHANGE_KEY_RST;
         wrong_limit_ff   <= WRONG_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BACKSPACE_KEY: backspace_key_ff <= csr_wdata;
            CSR_CLEAR_KEY:     clear_key_ff     <= csr_wdata;
            CSR_ENTER_KEY:     enter_key_ff     <= csr_wdata;
            CSR_DIGIT_LOW:     digit_low_ff     <= csr_wdata;
            CSR_DIGIT_HIGH:    digit_high_ff    <= csr_wdata;
            CSR_OPEN_KEY:      open_key_ff      <= csr_wdata;
            CSR_CHANGE_KEY:    change_key_ff    <= csr_wdata;
            CSR_WRONG_LIMIT:   wrong_limit_ff   <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign timer = item_ff.mode;

   // entry key classification
   always_comb begin
      priority if (item_ff.key == backspace_key_ff && count_ff != '0) begin
         ek = EK_BACK;
      end else if (item_ff.key == clear_key_ff) begin
         ek = EK_CLEAR;
      end else if (count_ff < CNT_W'(PASS_LEN) && item_ff.key >= digit_low_ff &&
                   item_ff.key <= digit_high_ff) begin
         ek = EK_DIGIT;
      end else if (count_ff == CNT_W'(PASS_LEN) && item_ff.key == enter_key_ff) begin
         ek = EK_SUBMIT;
      end else begin
         ek = EK_SKIP;
      end
   end

   assign entry_active = !timer && ((top_ff == ST_CHANGE && (step_ff == 2'd0 || step_ff == 2'd1))
                                    || (top_ff == ST_AUTH && step_ff == 2'd0));
   assign trial_bump   = (trial_ff == '1) ? trial_ff : trial_ff + 1'b1;

   always_comb begin
      top_in         = top_ff;
      prior_in       = prior_ff;
      step_in        = step_ff;
      first_in       = first_ff;
      trial_in       = trial_ff;
      count_in       = count_ff;
      cmd_in         = CMD_NONE;
      tload_in       = TL_NONE;
      op             = '0;
      op.wr_data     = item_ff.key;
      if (seq_ff == S_DECODE) begin
         if (entry_active) begin
            unique case (ek)
               EK_BACK: begin
                  count_in = count_ff - 1'b1;
                  cmd_in   = CMD_ERASE_LAST;
               end
               EK_CLEAR: begin
                  count_in = '0;
                  cmd_in   = CMD_ERASE_ALL;
               end
               EK_DIGIT: begin
                  op.wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
                  cmd_in   = CMD_DIGIT_OK;
               end
               EK_SUBMIT: begin
                  count_in = '0;
                  if (top_ff == ST_CHANGE && step_ff == 2'd0) begin
                     op.copy_new = 1'b1;
                     step_in     = 2'd1;
                     cmd_in      = CMD_CONFIRM_PASS;
                  end else begin
                     op.cmp_start  = 1'b1;
                     op.cmp_stored = (top_ff == ST_AUTH);
                  end
               end
               default: cmd_in = CMD_KEY_SKIPPED;
            endcase
         end else begin
            unique case (top_ff)
               ST_MENU: begin
                  if (!timer && step_ff == 2'd0) begin
                     priority if (item_ff.key == open_key_ff) begin
                        top_in   = ST_AUTH;
                        prior_in = ST_OPEN;
                        step_in  = 2'd0;
                        trial_in = '0;
                        cmd_in   = CMD_ENTER_PASS;
                     end else if (item_ff.key == change_key_ff) begin
                        trial_in = '0;
                        step_in  = 2'd0;
                        if (first_ff) begin
                           top_in   = ST_CHANGE;
                           prior_in = ST_MENU;
                           cmd_in   = CMD_NEW_PASS;
                        end else begin
                           top_in   = ST_AUTH;
                           prior_in = ST_CHANGE;
                           cmd_in   = CMD_ENTER_PASS;
                        end
                     end else begin
                        cmd_in = CMD_MENU_REJECT;
                     end
                  end
               end
               ST_CHANGE: begin
                  if (timer && step_ff == 2'd2) begin
                     top_in   = ST_MENU;
                     prior_in = ST_CHANGE;
                     step_in  = 2'd0;
                     cmd_in   = CMD_SHOW_MENU;
                  end else if (timer && step_ff == 2'd3) begin
                     step_in = 2'd0;
                     if (first_ff || prior_ff == ST_AUTH) begin
                        cmd_in = CMD_NEW_PASS;
                     end else begin
                        top_in   = ST_AUTH;
                        prior_in = ST_CHANGE;
                        trial_in = '0;
                        cmd_in   = CMD_ENTER_PASS;
                     end
                  end
               end
               ST_OPEN: begin
                  if (timer && step_ff == 2'd0) begin
                     step_in  = 2'd1;
                     cmd_in   = CMD_UNLOCKED;
                     tload_in = TL_HOLD;
                  end else if (timer && step_ff == 2'd1) begin
                     step_in  = 2'd2;
                     cmd_in   = CMD_LOCKING;
                     tload_in = TL_LOCK;
                  end else if (timer && step_ff == 2'd2) begin
                     top_in   = ST_MENU;
                     prior_in = ST_OPEN;
                     step_in  = 2'd0;
                     cmd_in   = CMD_SHOW_MENU;
                  end
               end
               default: begin
                  if (timer && step_ff == 2'd1) begin
                     step_in = 2'd0;
                     cmd_in  = CMD_ENTER_PASS;
                  end else if (timer && step_ff == 2'd2) begin
                     top_in   = ST_MENU;
                     prior_in = ST_AUTH;
                     step_in  = 2'd0;
                     cmd_in   = CMD_SHOW_MENU;
                  end
               end
            endcase
         end
      end else if (seq_ff == S_CMP && stat.cmp_done) begin
         if (top_ff == ST_CHANGE) begin
            tload_in = TL_MESSAGE;
            if (stat.cmp_equal) begin
               op.commit = 1'b1;
               first_in  = 1'b0;
               cmd_in    = CMD_PASS_CHANGED;
               step_in   = 2'd2;
            end else begin
               cmd_in   = CMD_MISMATCH;
               trial_in = first_ff ? trial_ff : trial_bump;
               step_in  = (trial_in < LIM_W'(MISMATCH_TRIES)) ? 2'd3 : 2'd2;
            end
         end else begin
            if (stat.cmp_equal) begin
               prior_in = ST_AUTH;
               step_in  = 2'd0;
               if (prior_ff == ST_OPEN) begin
                  top_in   = ST_OPEN;
                  cmd_in   = CMD_UNLOCKING;
                  tload_in = TL_UNLOCK;
               end else begin
                  top_in   = ST_CHANGE;
                  trial_in = '0;
                  cmd_in   = CMD_NEW_PASS;
               end
            end else begin
               trial_in = trial_bump;
               if (trial_bump < wrong_limit_ff) begin
                  cmd_in   = CMD_WRONG_PASS;
                  tload_in = TL_MESSAGE;
                  step_in  = 2'd1;
               end else begin
                  cmd_in   = CMD_DENIED;
                  tload_in = TL_WARNING;
                  step_in  = 2'd2;
               end
            end
         end
      end
   end

   always_comb begin
      motor = MOTOR_STOP;
      if (top_ff == ST_OPEN && step_ff == 2'd0) begin
         motor = MOTOR_FORWARD;
      end else if (top_ff == ST_OPEN && step_ff == 2'd2) begin
         motor = MOTOR_REVERSE;
      end
      buzz = (top_ff == ST_AUTH && step_ff == 2'd2);
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         S_IDLE:   if (req_valid) seq_in = S_DECODE;
         S_DECODE: seq_in = op.cmp_start ? S_CMP : S_POST;
         S_CMP:    if (stat.cmp_done) seq_in = S_POST;
         default:  if (slot_free) seq_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_IDLE;
         top_ff       <= ST_CHANGE;
         prior_ff     <= ST_CHANGE;
         step_ff      <= 2'd0;
         first_ff     <= 1'b1;
         trial_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         if (seq_ff == S_IDLE && req_valid) begin
            item_ff <= req_data;
         end
         if (seq_ff == S_DECODE || (seq_ff == S_CMP && stat.cmp_done)) begin
            top_ff   <= top_in;
            prior_ff <= prior_in;
            step_ff  <= step_in;
            first_ff <= first_in;
            trial_ff <= trial_in;
            count_ff <= count_in;
            cmd_ff   <= cmd_in;
            tload_ff <= tload_in;
         end
         if (seq_ff == S_POST && slot_free) begin
            rsp_valid_ff             <= 1'b1;
            rsp_data_ff.command      <= cmd_ff;
            rsp_data_ff.motor_drive  <= motor;
            rsp_data_ff.buzzer       <= buzz;
            rsp_data_ff.timer_load   <= tload_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (seq_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   kplc_store #(
      .PASS_LEN (PASS_LEN),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .wr_idx (count_ff[IDX_W-1:0]),
      .stat   (stat)
   );

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in progress");

   a_cmp_done_in_cmp: assert property (@(posedge clock) disable iff (reset)
      stat.cmp_done |-> seq_ff == S_CMP)
      else $error("compare finished outside the compare phase");

   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PASS_LEN))
      else $error("entry count beyond password length");

   a_buzzer_motor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.buzzer |-> rsp_data.motor_drive == MOTOR_STOP)
      else $error("buzzer and motor active together");

endmodule
